// File: sv/urh_pkg.sv
// ----------------------------------------------------------------------------
// urh_pkg: shared types for the undo/redo history ring
// Opcodes, controller state encoding and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package urh_pkg;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_READ = 2'd1,
		OP_UNDO = 2'd2,
		OP_REDO = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

// File: sv/urh_ctrl.sv
// ----------------------------------------------------------------------------
// urh_ctrl: operation sequencer
// Accepts one operation, runs it through the datapath, strobes the result.
// ----------------------------------------------------------------------------
module urh_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output urh_pkg::cmd_t cmd
);
	import urh_pkg::*;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = ST_EXEC;
			end
			ST_EXEC: state_d = ST_RESP;
			ST_RESP: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = (state_q == ST_RESP);
	assign cmd.load = (state_q == ST_IDLE) && start;
	assign cmd.exec = (state_q == ST_EXEC);

endmodule

// File: sv/urh_dp.sv
// ----------------------------------------------------------------------------
// urh_dp: history ring datapath
// Pointers, counts, the circular store and the result registers.
// ----------------------------------------------------------------------------
module urh_dp #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  urh_pkg::cmd_t cmd,
	input  logic [1:0]    opcode,
	input  logic [31:0]   entry_data,
	input  logic [3:0]    read_index,
	output logic          status,
	output logic [31:0]   result_data
);
	import urh_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (CW > 4) ? CW : 4;
	localparam int SW = ((PW > 4) ? PW : 4) + 1;
	localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL  = CW'(DEPTH);
	localparam logic [CW-1:0] ONE   = CW'(1);
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	opcode_t               op_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [3:0]            idx_q;

	logic [PW-1:0] oldest_q;
	logic [PW-1:0] cur_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] valid_q;

	logic                  err_q;
	logic                  zero_q;
	logic [DATA_WIDTH-1:0] rd_q;

	logic [PW-1:0] cur_inc;
	logic [PW-1:0] cur_dec;
	logic [PW-1:0] oldest_inc;
	logic [SW-1:0] rsum;
	logic [PW-1:0] raddr;
	logic [PW-1:0] addr;
	logic          err;
	logic          we;

	assign cur_inc    = (cur_q == LAST) ? '0 : cur_q + PW'(1);
	assign cur_dec    = (cur_q == '0) ? LAST : cur_q - PW'(1);
	assign oldest_inc = (oldest_q == LAST) ? '0 : oldest_q + PW'(1);
	assign rsum       = SW'(oldest_q) + SW'(idx_q);
	assign raddr      = (rsum >= DEPTH_S) ? PW'(rsum - DEPTH_S) : PW'(rsum);

	always_comb begin
		err  = 1'b0;
		we   = 1'b0;
		addr = raddr;
		case (op_q)
			OP_PUSH: begin
				we   = 1'b1;
				addr = cur_inc;
			end
			OP_READ: err = (IW'(idx_q) >= IW'(total_q));
			OP_UNDO: begin
				err  = (valid_q <= ONE);
				addr = cur_dec;
			end
			OP_REDO: begin
				err  = (valid_q >= total_q);
				addr = cur_inc;
			end
			default: err = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode_t'(opcode);
			data_q <= DATA_WIDTH'(entry_data);
			idx_q  <= read_index;
		end
		if (cmd.exec) begin
			err_q  <= err;
			zero_q <= err || (op_q == OP_PUSH);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (we)
				mem[addr] <= data_q;
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			cur_q    <= LAST;
			total_q  <= '0;
			valid_q  <= '0;
		end else if (cmd.exec && !err) begin
			case (op_q)
				OP_PUSH: begin
					cur_q <= cur_inc;
					if (valid_q < FULL) begin
						total_q <= valid_q + ONE;
						valid_q <= valid_q + ONE;
					end else begin
						total_q  <= valid_q;
						oldest_q <= oldest_inc;
					end
				end
				OP_UNDO: begin
					cur_q   <= cur_dec;
					valid_q <= valid_q - ONE;
				end
				OP_REDO: begin
					cur_q   <= cur_inc;
					valid_q <= valid_q + ONE;
				end
				default: ;
			endcase
		end
	end

	assign status      = err_q;
	assign result_data = zero_q ? 32'd0 : 32'(rd_q);

endmodule

// File: sv/undo_redo_history_ring.sv
// ----------------------------------------------------------------------------
// undo_redo_history_ring: bounded undo/redo history in a circular store
// Sequence: idle takes start and captures the operation, exec accesses the store
// and registers the read, resp strobes done; a new operation is taken only in
// idle, busy is high in exec and resp. Reset: counts and oldest pointer clear;
// the current pointer goes to the last slot; store is undefined until written.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module undo_redo_history_ring #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] entry_data,
	input  logic [3:0]  read_index,
	output logic        done,
	output logic        status,
	output logic [31:0] result_data
);
	import urh_pkg::*;

	cmd_t cmd;

	urh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	urh_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.opcode      (opcode),
		.entry_data  (entry_data),
		.read_index  (read_index),
		.status      (status),
		.result_data (result_data)
	);

endmodule
